FILE: design/rarms_pkg.sv
// Package for the range add / reverse / maximum sequence block.
// Holds the shared widths, opcodes, the controller state type and the
// request decode record; depends on nothing.
package rarms_pkg;

   localparam int DATA_W    = 32;
   localparam int IDX_W     = 11;
   localparam int CMP_W     = 17;   // holds any length up to 65536
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;
   localparam logic [IDX_W-1:0] LEN_RESET = 11'd1024;

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_REVERSE = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;

   localparam logic [PADDR_W-1:0] ADDR_SEQ_LEN = 3'd0;

   localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_REV_RD_LO,
      ST_REV_RD_HI,
      ST_REV_WR_LO,
      ST_REV_WR_HI,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             bad;
      logic [CMP_W-1:0] lo_addr;
      logic [CMP_W-1:0] hi_addr;
   } decode_type;

endpackage

FILE: design/rarms_check.sv
// Request decoder: checks the opcode and the range against the length in use
// and turns the 1-based indices into 0-based addresses. Uses rarms_pkg.
module rarms_check #(
   parameter int MAX_LENGTH = 1024
) (
   input  logic [1:0]                  opcode,
   input  logic [rarms_pkg::IDX_W-1:0] left_index,
   input  logic [rarms_pkg::IDX_W-1:0] right_index,
   input  logic [rarms_pkg::IDX_W-1:0] seq_len,
   output rarms_pkg::decode_type       decode
);
   import rarms_pkg::*;

   logic [CMP_W-1:0] len_wide;
   logic [CMP_W-1:0] eff_len;
   logic [CMP_W-1:0] left_wide;
   logic [CMP_W-1:0] right_wide;
   logic             op_bad;

   always_comb begin
      len_wide   = CMP_W'(seq_len);
      left_wide  = CMP_W'(left_index);
      right_wide = CMP_W'(right_index);
      // A length beyond the store saturates to the store depth.
      eff_len    = (len_wide > CMP_W'(MAX_LENGTH)) ? CMP_W'(MAX_LENGTH) : len_wide;
      op_bad     = (opcode != OP_ADD) && (opcode != OP_REVERSE) && (opcode != OP_QUERY);
      decode.bad = op_bad || (left_wide == '0) || (left_wide > right_wide) ||
                   (right_wide > eff_len);
      decode.lo_addr = left_wide - CMP_W'(1);
      decode.hi_addr = right_wide - CMP_W'(1);
   end

endmodule

FILE: design/range_add_reverse_max_sequence.sv
// Top level of the range add / reverse / maximum sequence block.
// Depends on rarms_pkg and rarms_check; holds the element store.
//
// Usage. A transaction is taken at a rising edge with start high and busy
// low; it carries an opcode (add, reverse, query) and a 1-based inclusive
// range, plus an amount for add. Unless a length write cuts it short, every
// transaction yields exactly one result on rsp_range_max and rsp_status,
// shown for one cycle with rsp_strobe high. The receiver cannot hold results
// off, so the block never waits on it. A rejected transaction (unused opcode
// or bad range) gives its result in the cycle after acceptance and leaves
// the store alone. All elements live in one synchronous memory with one read
// and one write port and registered read data; that single port pair sets
// the rate. Add and query read one element a cycle and retire each read in
// the cycle after it, with the write-back or the maximum; reverse makes two
// reads and two writes for each swapped pair. Busy stays high until the
// result is shown; one transaction is worked on at a time.
// After reset, and after every write of the length register, a clearing pass
// writes zero to all MAX_LENGTH entries, one a cycle, with busy high; the
// register port stays open throughout and a fresh write restarts the pass.
module range_add_reverse_max_sequence #(
   parameter int MAX_LENGTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_opcode,
   input  logic [rarms_pkg::IDX_W-1:0]         req_left_index,
   input  logic [rarms_pkg::IDX_W-1:0]         req_right_index,
   input  logic signed [rarms_pkg::DATA_W-1:0] req_add_amount,
   // result channel
   output logic                                rsp_strobe,
   output logic signed [rarms_pkg::DATA_W-1:0] rsp_range_max,
   output logic                                rsp_status,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rarms_pkg::PADDR_W-1:0]       paddr,
   input  logic [rarms_pkg::PDATA_W-1:0]       pwdata,
   output logic [rarms_pkg::PDATA_W-1:0]       prdata,
   output logic                                pready
);
   import rarms_pkg::*;

   localparam int AW = $clog2(MAX_LENGTH);

   // The element store, with its registered read data.
   logic [DATA_W-1:0] store_mem [MAX_LENGTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          len_ff, len_in;
   logic [1:0]                op_ff, op_in;
   logic signed [DATA_W-1:0]  amt_ff, amt_in;
   logic [AW-1:0]             lo_ff, lo_in;
   logic [AW-1:0]             hi_ff, hi_in;
   logic [AW-1:0]             ptr_ff, ptr_in;
   logic                      pend_ff, pend_in;
   logic [AW-1:0]             wb_addr_ff, wb_addr_in;
   logic signed [DATA_W-1:0]  best_ff, best_in;
   logic [DATA_W-1:0]         tmp_ff, tmp_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic signed [DATA_W-1:0]  rsp_max_ff, rsp_max_in;
   logic                      rsp_status_ff, rsp_status_in;

   decode_type                decode;
   logic                      csr_write;
   logic signed [DATA_W:0]    sum_wide;
   logic signed [DATA_W-1:0]  sum_sat;
   logic signed [DATA_W-1:0]  rd_value;

   rarms_check #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_check (
      .opcode      (req_opcode),
      .left_index  (req_left_index),
      .right_index (req_right_index),
      .seq_len     (len_ff),
      .decode      (decode)
   );

   // Single read port and single write port, with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr == ADDR_SEQ_LEN) ? PDATA_W'(len_ff) : '0;

   // Saturating add of the amount onto the element that has just been read.
   always_comb begin
      rd_value = $signed(rd_data_ff);
      sum_wide = {rd_value[DATA_W-1], rd_value} + {amt_ff[DATA_W-1], amt_ff};
      if (sum_wide[DATA_W] != sum_wide[DATA_W-1]) begin
         sum_sat = sum_wide[DATA_W] ? DATA_MIN : DATA_MAX;
      end else begin
         sum_sat = sum_wide[DATA_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      op_in         = op_ff;
      amt_in        = amt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      ptr_in        = ptr_ff;
      pend_in       = 1'b0;
      wb_addr_in    = wb_addr_ff;
      best_in       = best_ff;
      tmp_in        = tmp_ff;
      rsp_strobe_in = 1'b0;
      rsp_max_in    = rsp_max_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = '0;

      // Add and query both retire the element whose read was issued last cycle.
      if (pend_ff) begin
         if (op_ff == OP_ADD) begin
            wr_en   = 1'b1;
            wr_addr = wb_addr_ff;
            wr_data = sum_sat;
         end else if (rd_value > best_ff) begin
            best_in = rd_value;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = '0;
            if (ptr_ff == AW'(MAX_LENGTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (decode.bad) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = 1'b1;
                  rsp_max_in    = '0;
               end else begin
                  op_in   = req_opcode;
                  amt_in  = req_add_amount;
                  lo_in   = decode.lo_addr[AW-1:0];
                  hi_in   = decode.hi_addr[AW-1:0];
                  ptr_in  = decode.lo_addr[AW-1:0];
                  best_in = DATA_MIN;
                  if (req_opcode == OP_REVERSE) begin
                     state_in = ST_REV_RD_LO;
                  end else begin
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            rd_en      = 1'b1;
            rd_addr    = ptr_ff;
            pend_in    = 1'b1;
            wb_addr_in = ptr_ff;
            if (ptr_ff == hi_ff) begin
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_REV_RD_LO: begin
            if (lo_ff >= hi_ff) begin
               state_in = ST_FINISH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = lo_ff;
               state_in = ST_REV_RD_HI;
            end
         end
         ST_REV_RD_HI: begin
            tmp_in   = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = hi_ff;
            state_in = ST_REV_WR_LO;
         end
         ST_REV_WR_LO: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff;
            wr_data  = rd_data_ff;
            state_in = ST_REV_WR_HI;
         end
         ST_REV_WR_HI: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            wr_data  = tmp_ff;
            lo_in    = lo_ff + AW'(1);
            hi_in    = hi_ff - AW'(1);
            state_in = ST_REV_RD_LO;
         end
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = 1'b0;
            rsp_max_in    = (op_ff == OP_QUERY) ? best_ff : '0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A length write restarts the clearing pass from the first entry.
      if (csr_write && (paddr == ADDR_SEQ_LEN)) begin
         len_in   = pwdata[IDX_W-1:0];
         state_in = ST_CLEAR;
         ptr_in   = '0;
         pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         len_ff        <= LEN_RESET;
         ptr_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         ptr_ff        <= ptr_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      amt_ff        <= amt_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      wb_addr_ff    <= wb_addr_in;
      best_ff       <= best_in;
      tmp_ff        <= tmp_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_range_max = rsp_max_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

FILE: design/rarms_checker.sv
// Port-level checks for the range add / reverse / maximum sequence block,
// bound to its top level. Uses rarms_pkg for widths and register addresses.
module rarms_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_strobe,
   input logic signed [rarms_pkg::DATA_W-1:0] rsp_range_max,
   input logic                                rsp_status,
   input logic                                psel,
   input logic                                penable,
   input logic                                pwrite,
   input logic [rarms_pkg::PADDR_W-1:0]       paddr,
   input logic                                pready
);
   import rarms_pkg::*;

   // An accepted transaction either gives its rejection at once or keeps
   // the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted transaction neither answered nor in progress");

   // A result never appears out of nowhere.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start) || $past(busy)))
      else $error("result without a transaction");

   // A rejected transaction carries a zero maximum.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (rsp_range_max == '0))
      else $error("rejected transaction with non-zero maximum");

   // A length write starts the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && (paddr == ADDR_SEQ_LEN)) |=> busy)
      else $error("length write did not start the clearing pass");

   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port not ready");

endmodule

bind range_add_reverse_max_sequence rarms_checker u_rarms_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_range_max (rsp_range_max),
   .rsp_status    (rsp_status),
   .psel          (psel),
   .penable       (penable),
   .pwrite        (pwrite),
   .paddr         (paddr),
   .pready        (pready)
);

FILE: test/rarms_checker.sv
`timescale 1ns / 100ps
// Checker for the range add / reverse / maximum sequence block.
// It watches the request, result and register channels, predicts each result from its
// own copy of the sequence and compares them. Depends on rarms_pkg.
module rarms_seq_checker #(
   parameter int MAX_LENGTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [1:0]                          req_opcode,
   input  logic [rarms_pkg::IDX_W-1:0]         req_left_index,
   input  logic [rarms_pkg::IDX_W-1:0]         req_right_index,
   input  logic signed [rarms_pkg::DATA_W-1:0] req_add_amount,
   input  logic                                rsp_strobe,
   input  logic signed [rarms_pkg::DATA_W-1:0] rsp_range_max,
   input  logic                                rsp_status,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rarms_pkg::PADDR_W-1:0]       paddr,
   input  logic [rarms_pkg::PDATA_W-1:0]       pwdata,
   input  logic [rarms_pkg::PDATA_W-1:0]       prdata,
   input  logic                                pready,
   input  logic                                run_over,
   output int                                  pending_results,
   output int                                  failure_count,
   output int                                  results_seen,
   output int                                  rejects_seen
);
   import rarms_pkg::*;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_BAD  = 1'b1;

   typedef struct packed {
      logic signed [DATA_W-1:0] range_max;
      logic                     status;
   } outcome_type;

   logic signed [DATA_W-1:0] elements [MAX_LENGTH];
   logic [IDX_W-1:0]         length_reg;
   outcome_type              awaited_outcomes [$];
   int                       mismatches = 0;
   int                       result_total = 0;
   int                       reject_total = 0;
   bit                       leftovers_counted = 1'b0;

   assign failure_count = mismatches;
   assign results_seen  = result_total;
   assign rejects_seen  = reject_total;

   // Applies one request to the local sequence and returns the result it should give.
   function automatic outcome_type apply_request(input logic [1:0] op,
                                                 input logic [IDX_W-1:0] lo,
                                                 input logic [IDX_W-1:0] hi,
                                                 input logic signed [DATA_W-1:0] amount);
      outcome_type              outcome;
      int unsigned              usable;
      int unsigned              first;
      int unsigned              last;
      int unsigned              k;
      longint                   sum;
      logic signed [DATA_W-1:0] held;
      outcome.range_max = '0;
      outcome.status    = STATUS_DONE;
      usable = (length_reg > MAX_LENGTH) ? MAX_LENGTH : length_reg;
      if (lo == 0 || lo > hi || hi > usable ||
          (op != OP_ADD && op != OP_REVERSE && op != OP_QUERY)) begin
         outcome.status = STATUS_BAD;
         return outcome;
      end
      first = lo - 1;
      last  = hi - 1;
      case (op)
         OP_ADD: begin
            for (k = first; k <= last; k++) begin
               sum = longint'(elements[k]) + longint'(amount);
               if (sum > longint'(DATA_MAX)) sum = longint'(DATA_MAX);
               if (sum < longint'(DATA_MIN)) sum = longint'(DATA_MIN);
               elements[k] = sum[DATA_W-1:0];
            end
         end
         OP_REVERSE: begin
            while (first < last) begin
               held            = elements[first];
               elements[first] = elements[last];
               elements[last]  = held;
               first++;
               last--;
            end
         end
         default: begin
            held = elements[first];
            for (k = first + 1; k <= last; k++)
               if (elements[k] > held) held = elements[k];
            outcome.range_max = held;
         end
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         foreach (elements[k]) elements[k] = '0;
         length_reg = LEN_RESET;
         awaited_outcomes.delete();
      end else begin
         // A result may share an edge with the next request, so it is retired first.
         if (rsp_strobe) begin
            result_total++;
            if (rsp_status === STATUS_BAD) reject_total++;
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: unexpected result range_max=%0d status=%0b",
                        $time, rsp_range_max, rsp_status);
               mismatches++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0b, got %0b",
                           $time, want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_range_max !== want.range_max) begin
                  $display("%0t: range_max expected %0d, got %0d",
                           $time, want.range_max, rsp_range_max);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            awaited_outcomes.push_back(apply_request(req_opcode, req_left_index,
                                                     req_right_index, req_add_amount));
         if (psel && penable && pready && paddr == ADDR_SEQ_LEN) begin
            if (pwrite) begin
               length_reg = pwdata[IDX_W-1:0];
               foreach (elements[k]) elements[k] = '0;
            end else if (prdata !== PDATA_W'(length_reg)) begin
               $display("%0t: sequence_length read expected %0d, got %0d",
                        $time, length_reg, prdata);
               mismatches++;
            end
         end
         if (run_over && !leftovers_counted) begin
            leftovers_counted = 1'b1;
            if (awaited_outcomes.size() != 0) begin
               $display("%0t: %0d results expected but never seen",
                        $time, awaited_outcomes.size());
               mismatches += awaited_outcomes.size();
            end
         end
      end
      pending_results <= awaited_outcomes.size();
   end

endmodule

FILE: test/range_add_reverse_max_sequence_tb.sv
`timescale 1ns / 100ps
// Testbench top for range_add_reverse_max_sequence: clock, reset, stimulus and verdict.
// Depends on rarms_pkg, the block itself and rarms_seq_checker, which checks results and register reads.
module range_add_reverse_max_sequence_tb;
   import rarms_pkg::*;

   localparam int         MAX_LEN     = 1024;
   // The fourth opcode is unused by the block and must be rejected.
   localparam logic [1:0] OP_SPARE    = 2'd3;
   // These bounds leave ample margin even for a full-length reverse.
   localparam int         DRAIN_LIMIT = 10000;
   localparam int         TAIL_CYCLES = 2100;
   localparam int         NUM_PHASES  = 8;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_opcode;
   logic [IDX_W-1:0]         req_left_index;
   logic [IDX_W-1:0]         req_right_index;
   logic signed [DATA_W-1:0] req_add_amount;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_range_max;
   logic                     rsp_status;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [PADDR_W-1:0]       paddr;
   logic [PDATA_W-1:0]       pwdata;
   logic [PDATA_W-1:0]       prdata;
   logic                     pready;
   logic                     run_over;
   int                       pending_results;
   int                       failure_count;
   int                       results_seen;
   int                       rejects_seen;

   // When this is clear, requests are sent back to back. It is redrawn every 24 random
   // transactions, so that stretches with gaps alternate with stretches without them.
   bit gaps_on;
   int requests_sent;
   int phases_run;

   range_add_reverse_max_sequence #(
      .MAX_LENGTH(MAX_LEN)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_left_index (req_left_index),
      .req_right_index(req_right_index),
      .req_add_amount (req_add_amount),
      .rsp_strobe     (rsp_strobe),
      .rsp_range_max  (rsp_range_max),
      .rsp_status     (rsp_status),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   rarms_seq_checker #(
      .MAX_LENGTH(MAX_LEN)
   ) seq_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_left_index (req_left_index),
      .req_right_index(req_right_index),
      .req_add_amount (req_add_amount),
      .rsp_strobe     (rsp_strobe),
      .rsp_range_max  (rsp_range_max),
      .rsp_status     (rsp_status),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .run_over       (run_over),
      .pending_results(pending_results),
      .failure_count  (failure_count),
      .results_seen   (results_seen),
      .rejects_seen   (rejects_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. The slowest correct run, with every transaction a full-length reverse and
   // the longest gap before it, needs about 12 ms; this allows several times that.
   initial begin
      #60_000_000;
      $display("range_add_reverse_max_sequence_tb NOT OK");
      $finish;
   end

   // Presents one transaction and returns at the edge that accepts it. With a gap of zero,
   // start is left high from the previous transaction, so only one assignment is made to
   // it in that time step.
   task automatic send(input logic [1:0] op, input logic [IDX_W-1:0] lo,
                       input logic [IDX_W-1:0] hi, input logic signed [DATA_W-1:0] amount);
      int gap;
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_opcode      <= op;
      req_left_index  <= lo;
      req_right_index <= hi;
      req_add_amount  <= amount;
      do @(posedge clock); while (busy !== 1'b0);
      requests_sent++;
   endtask

   // Drops start and waits until the checker holds no outstanding result. Every
   // transaction yields a result, so the block is idle once this returns.
   task automatic wait_for_results();
      int waited;
      start  <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (pending_results != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Writes sequence_length and reads it back. The bus is left idle after each
   // transfer, so that the next transfer can start cleanly.
   task automatic program_length(input logic [IDX_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_SEQ_LEN;
      pwdata  <= PDATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      psel    <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // One random transaction for a sequence whose usable length is usable. Most are
   // well-formed ranges of up to 40 elements, with an occasional full-length range. The
   // rest are malformed: a zero left index, crossed indices, a range past the end, the
   // unused opcode, or fully random fields.
   task automatic random_request(input int unsigned usable);
      int unsigned              span;
      int unsigned              lo;
      int unsigned              hi;
      int unsigned              pick;
      logic [1:0]               op;
      logic signed [DATA_W-1:0] amount;
      pick = $urandom_range(0, 99);
      op   = (pick < 40) ? OP_ADD : (pick < 65) ? OP_REVERSE : OP_QUERY;
      case ($urandom_range(0, 5))
         0:       amount = $urandom;
         1:       amount = DATA_MAX - $urandom_range(0, 3);
         2:       amount = DATA_MIN + $urandom_range(0, 3);
         default: amount = int'($urandom_range(0, 2000)) - 1000;
      endcase
      if (usable == 0 || $urandom_range(0, 99) < 12) begin
         case ($urandom_range(0, 4))
            0: begin
               lo = 0;
               hi = $urandom_range(0, 2047);
            end
            1: begin
               lo = $urandom_range(2, 2047);
               hi = $urandom_range(1, lo - 1);
            end
            2: begin
               hi = $urandom_range(usable + 1, 2047);
               lo = $urandom_range(1, hi);
            end
            3: begin
               op = OP_SPARE;
               lo = (usable > 0) ? $urandom_range(1, usable) : 1;
               hi = (usable > 0) ? $urandom_range(lo, usable) : 1;
            end
            default: begin
               op = 2'($urandom_range(0, 3));
               lo = $urandom_range(0, 2047);
               hi = $urandom_range(0, 2047);
            end
         endcase
      end else begin
         span = ($urandom_range(0, 99) < 3) ? usable
                                            : $urandom_range(1, (usable < 40) ? usable : 40);
         lo   = $urandom_range(1, usable - span + 1);
         hi   = lo + span - 1;
      end
      send(op, IDX_W'(lo), IDX_W'(hi), amount);
   endtask

   initial begin : stimulus
      // Lengths run through the extremes: an oversized value that saturates, one, zero
      // (every range is bad), the maximum, and a few in between.
      int unsigned lengths [NUM_PHASES];
      int unsigned counts  [NUM_PHASES];
      int unsigned usable;
      int          n;
      lengths = '{2047, 1, 0, 2, 37, 1024, 5, 300};
      counts  = '{90, 30, 10, 40, 90, 128, 50, 120};
      requests_sent = 0;
      phases_run    = 0;
      gaps_on         = 1'b0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_opcode      <= OP_ADD;
      req_left_index  <= '0;
      req_right_index <= '0;
      req_add_amount  <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= ADDR_SEQ_LEN;
      pwdata          <= '0;
      run_over        <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset length of 1024: saturation at both limits, full-length
      // and odd-length reversals, single-element ranges, every kind of bad range and the
      // unused opcode. The block clears its store first; send waits for busy to drop.
      send(OP_ADD,     11'd1,    11'd1024, DATA_MAX);
      send(OP_ADD,     11'd1,    11'd1,    32'sd1);
      send(OP_QUERY,   11'd1,    11'd1024, '0);
      send(OP_ADD,     11'd1024, 11'd1024, DATA_MIN);
      send(OP_ADD,     11'd1024, 11'd1024, DATA_MIN);
      send(OP_QUERY,   11'd1024, 11'd1024, '0);
      send(OP_REVERSE, 11'd1,    11'd1024, '0);
      send(OP_QUERY,   11'd1,    11'd1,    '0);
      send(OP_REVERSE, 11'd7,    11'd7,    '0);
      send(OP_REVERSE, 11'd1,    11'd2,    '0);
      send(OP_QUERY,   11'd1,    11'd2,    '0);
      gaps_on = 1'b1;
      send(OP_ADD,     11'd2,    11'd1023, -32'sd5);
      send(OP_QUERY,   11'd2,    11'd1023, '0);
      send(OP_REVERSE, 11'd1,    11'd1023, '0);
      send(OP_QUERY,   11'd1,    11'd1023, '0);
      send(OP_QUERY,   11'd0,    11'd5,    '0);
      send(OP_ADD,     11'd9,    11'd8,    32'sd3);
      send(OP_REVERSE, 11'd1,    11'd1025, '0);
      send(OP_ADD,     11'd2047, 11'd2047, -32'sd1);
      send(OP_SPARE,   11'd1,    11'd4,    32'sd1);
      send(OP_ADD,     11'd1,    11'd1024, DATA_MIN);
      send(OP_QUERY,   11'd1,    11'd1024, '0);
      wait_for_results();

      // Random part, one length setting at a time. Registers are only written once every
      // result of the previous phase has come back or DRAIN_LIMIT has run out.
      for (int p = 0; p < NUM_PHASES; p++) begin
         program_length(IDX_W'(lengths[p]));
         phases_run++;
         usable = (lengths[p] > MAX_LEN) ? MAX_LEN : lengths[p];
         for (n = 0; n < counts[p]; n++) begin
            if (n % 24 == 0) gaps_on = ($urandom_range(0, 1) == 1);
            random_request(usable);
         end
         wait_for_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      run_over <= 1'b1;
      repeat (2) @(posedge clock);
      $display("Sent %0d transactions over %0d sequence lengths (0, 1, 1024, oversized and others).",
               requests_sent, phases_run + 1);
      $display("Checked %0d results, %0d of them rejected; %0d mismatches.",
               results_seen, rejects_seen, failure_count);
      if (failure_count == 0) begin
         $display("range_add_reverse_max_sequence_tb OK");
      end else begin
         $display("range_add_reverse_max_sequence_tb NOT OK");
      end
      $finish;
   end

endmodule
